// ===== sv/hba_pkg.sv =====
package hba_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_ADDR_BITS  = 20;

  localparam int REQ_W  = 20;
  localparam int OFF_W  = 20;
  localparam int STAT_W = 2;
  localparam int MRG_W  = 2;
  localparam int POL_W  = 2;
  localparam int LIM_W  = 21;
  localparam int HDR_W  = 7;
  localparam int CFGI_W = 2;
  localparam int CFGD_W = 21;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADREL  = 2'd3;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;
  localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_FIT    = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_HEADER = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RST = 21'd1048576;
  localparam logic [HDR_W-1:0] HDR_RST   = 7'd24;

  typedef struct packed {
    logic load;
    logic scan;
    logic plan;
    logic shift;
    logic wr1;
    logic wr2;
    logic emit;
  } hba_cmd_t;

  typedef struct packed {
    logic scan_empty;
    logic scan_last;
    logic sh_go;
    logic sh_last;
  } hba_stat_t;

endpackage

// ===== sv/hba_ctrl.sv =====
module hba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  hba_pkg::hba_stat_t stat,
  output hba_pkg::hba_cmd_t  cmd
);
  import hba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_PLAN, S_SHIFT, S_SDRAIN, S_WR1, S_WR2, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_empty) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_PLAN;
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = stat.sh_go ? S_SHIFT : S_WR1;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.sh_last) state_nxt = S_SDRAIN;
      end
      S_SDRAIN: state_nxt = S_WR1;
      S_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/hba_datapath.sv =====
module hba_datapath #(
  parameter int MAX_BLOCKS = hba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = hba_pkg::DEF_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_command,
  input  logic [hba_pkg::REQ_W-1:0]  in_request_size,
  input  logic [hba_pkg::OFF_W-1:0]  in_block_offset,
  input  logic                       cfg_we,
  input  logic [hba_pkg::CFGI_W-1:0] cfg_index,
  input  logic [hba_pkg::CFGD_W-1:0] cfg_data,
  input  hba_pkg::hba_cmd_t          cmd,
  output hba_pkg::hba_stat_t         stat,
  output logic [hba_pkg::STAT_W-1:0] out_status,
  output logic [hba_pkg::OFF_W-1:0]  out_data_offset,
  output logic                       out_reused,
  output logic                       out_split_done,
  output logic [hba_pkg::MRG_W-1:0]  out_merges
);
  import hba_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = CW + 1;
  localparam int SW = ((ADDR_BITS > OFF_W) ? ADDR_BITS : OFF_W) + 2;
  localparam logic [SW-1:0] CAP = SW'(1) << ADDR_BITS;

  typedef struct packed {
    logic [SW-1:0] data;
    logic [SW-1:0] size;
    logic          free;
  } ent_t;

  ent_t mem [MAX_BLOCKS];
  ent_t rd_q;

  // configuration
  logic [POL_W-1:0] pol_r;
  logic [LIM_W-1:0] lim_r;
  logic [HDR_W-1:0] hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= POL_FIRST;
      lim_r <= LIMIT_RST;
      hdr_r <= HDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT:    pol_r <= cfg_data[POL_W-1:0];
        CFG_LIMIT:  lim_r <= cfg_data[LIM_W-1:0];
        CFG_HEADER: hdr_r <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // heap state
  logic [CW-1:0] count_r;
  logic [SW-1:0] top_r;
  logic          nf_valid_r;
  logic [IW-1:0] nf_pos_r;

  // request
  logic          op_r;
  logic [SW-1:0] need_r, tgt_r;
  logic [REQ_W:0] req_up;
  assign req_up = {1'b0, in_request_size} + (REQ_W+1)'(3);

  // scan
  logic [IW-1:0] ptr_r, ridx_r, start_sel;
  logic [CW-1:0] k_r;
  logic          rv_r;

  assign start_sel = (in_command == CMD_ALLOC && pol_r == POL_NEXT && nf_valid_r &&
                      CW'(nf_pos_r) < count_r) ? nf_pos_r : '0;
  assign stat.scan_empty = (count_r == '0);
  assign stat.scan_last  = (k_r + CW'(1) >= count_r);

  // search trackers
  logic          have_r, hit_r, hfree_r, grab_r, pexist_r, pfree_r, nexist_r, nfree_r, lfree_r;
  logic [IW-1:0] win_r, hidx_r;
  logic [SW-1:0] wdata_r, wsize_r, wrem_r, hsize_r, pdata_r, psize_r, nsize_r;
  logic [SW-1:0] ldata_r, lsize_r;
  logic          fit;
  logic [SW-1:0] rem;

  assign fit = rd_q.free && (rd_q.size >= need_r);
  assign rem = rd_q.size - need_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.scan;
    end
    ridx_r <= ptr_r;
    if (cmd.load) begin
      op_r   <= in_command;
      need_r <= SW'({req_up[REQ_W:2], 2'b00});
      tgt_r  <= SW'(in_block_offset);
      ptr_r  <= start_sel;
      k_r    <= '0;
      have_r <= 1'b0;
      hit_r  <= 1'b0;
      grab_r <= 1'b0;
      nexist_r <= 1'b0;
    end else if (cmd.scan) begin
      ptr_r <= (CW'(ptr_r) + CW'(1) == count_r) ? '0 : ptr_r + IW'(1);
      k_r   <= k_r + CW'(1);
    end
    if (rv_r) begin
      if (op_r == CMD_ALLOC) begin
        if (fit && (!have_r || (pol_r == POL_BEST && rem < wrem_r) ||
                    (pol_r == POL_WORST && rem > wrem_r))) begin
          have_r  <= 1'b1;
          win_r   <= ridx_r;
          wdata_r <= rd_q.data;
          wsize_r <= rd_q.size;
          wrem_r  <= rem;
        end
      end else begin
        if (!hit_r && rd_q.data == tgt_r) begin
          hit_r    <= 1'b1;
          hidx_r   <= ridx_r;
          hsize_r  <= rd_q.size;
          hfree_r  <= rd_q.free;
          pexist_r <= (ridx_r != '0);
          pdata_r  <= ldata_r;
          psize_r  <= lsize_r;
          pfree_r  <= lfree_r;
          grab_r   <= 1'b1;
        end else if (grab_r) begin
          grab_r   <= 1'b0;
          nexist_r <= 1'b1;
          nsize_r  <= rd_q.size;
          nfree_r  <= rd_q.free;
        end
      end
      ldata_r <= rd_q.data;
      lsize_r <= rd_q.size;
      lfree_r <= rd_q.free;
    end
  end

  // plan: decide the outcome and the table edits
  logic [SW-1:0] hdr_x, lim_x, grow_top;
  logic          split_ok, full, nx, pv;
  logic [1:0]    mcnt;
  logic [IW-1:0] base;
  logic [SW-1:0] newsize;
  logic [XW-1:0] first_dn;
  logic [IW-1:0] p1, p2;

  logic [STAT_W-1:0] p_status;
  logic [SW-1:0]     p_off;
  logic              p_reused, p_split;
  logic [1:0]        p_merges;
  logic              p_wr1_v, p_wr2_v, p_go, p_up;
  logic [IW-1:0]     p_wr1_a, p_wr2_a, p_sh_start, p_sh_end;
  ent_t              p_wr1_e, p_wr2_e;
  logic [CW-1:0]     p_count;
  logic [SW-1:0]     p_top;
  logic              p_nf_valid;
  logic [IW-1:0]     p_nf_pos;

  assign stat.sh_go = p_go;

  always_comb begin
    hdr_x    = SW'(hdr_r);
    lim_x    = (SW'(lim_r) < CAP) ? SW'(lim_r) : CAP;
    grow_top = top_r + hdr_x + need_r;
    full     = (count_r == CW'(MAX_BLOCKS));
    split_ok = (wsize_r - need_r > hdr_x + SW'(4)) && !full;
    nx       = nexist_r && nfree_r;
    pv       = pexist_r && pfree_r;
    mcnt     = {1'b0, nx} + {1'b0, pv};
    base     = pv ? hidx_r - IW'(1) : hidx_r;
    newsize  = (pv ? psize_r + hdr_x : '0) + hsize_r + (nx ? nsize_r + hdr_x : '0);
    first_dn = XW'(base) + XW'(1) + XW'(mcnt);
    p1 = (nx && XW'(nf_pos_r) >= XW'(hidx_r) + XW'(1)) ? nf_pos_r - IW'(1) : nf_pos_r;
    p2 = (pv && p1 >= hidx_r) ? p1 - IW'(1) : p1;

    p_status   = ST_OK;
    p_off      = '0;
    p_reused   = 1'b0;
    p_split    = 1'b0;
    p_merges   = '0;
    p_wr1_v    = 1'b0;
    p_wr1_a    = '0;
    p_wr1_e    = '0;
    p_wr2_v    = 1'b0;
    p_wr2_a    = '0;
    p_wr2_e    = '0;
    p_go       = 1'b0;
    p_up       = 1'b0;
    p_sh_start = '0;
    p_sh_end   = '0;
    p_count    = count_r;
    p_top      = top_r;
    p_nf_valid = nf_valid_r;
    p_nf_pos   = nf_pos_r;

    if (op_r == CMD_ALLOC) begin
      if (need_r == '0) begin
        p_status = ST_ZERO;
      end else begin
        p_nf_valid = have_r;
        p_nf_pos   = have_r ? win_r : '0;
        if (have_r) begin
          p_reused = 1'b1;
          p_off    = wdata_r;
          p_wr1_v  = 1'b1;
          if (split_ok) begin
            p_split    = 1'b1;
            p_count    = count_r + CW'(1);
            p_up       = 1'b1;
            p_go       = (XW'(count_r) >= XW'(win_r) + XW'(2));
            p_sh_start = IW'(count_r - CW'(1));
            p_sh_end   = win_r + IW'(1);
            p_wr1_a    = win_r + IW'(1);
            p_wr1_e    = '{data: wdata_r + need_r + hdr_x,
                           size: wsize_r - need_r - hdr_x, free: 1'b1};
            p_wr2_v    = 1'b1;
            p_wr2_a    = win_r;
            p_wr2_e    = '{data: wdata_r, size: need_r, free: 1'b0};
          end else begin
            p_wr1_a = win_r;
            p_wr1_e = '{data: wdata_r, size: wsize_r, free: 1'b0};
          end
        end else if (full || grow_top > lim_x) begin
          p_status = ST_NOSPACE;
        end else begin
          p_off   = top_r + hdr_x;
          p_wr1_v = 1'b1;
          p_wr1_a = IW'(count_r);
          p_wr1_e = '{data: top_r + hdr_x, size: need_r, free: 1'b0};
          p_count = count_r + CW'(1);
          p_top   = grow_top;
        end
      end
    end else if (!hit_r || hfree_r) begin
      p_status = ST_BADREL;
    end else begin
      p_merges   = mcnt;
      p_wr1_v    = 1'b1;
      p_wr1_a    = base;
      p_wr1_e    = '{data: pv ? pdata_r : tgt_r, size: newsize, free: 1'b1};
      p_count    = count_r - CW'(mcnt);
      p_go       = (mcnt != '0) && (first_dn < XW'(count_r));
      p_sh_start = IW'(first_dn);
      p_sh_end   = IW'(count_r - CW'(1));
      if (nf_valid_r) p_nf_pos = p2;
    end
  end

  logic [STAT_W-1:0] r_status;
  logic [SW-1:0]     r_off;
  logic              r_reused, r_split;
  logic [1:0]        r_merges;
  logic              wr1_v_r, wr2_v_r, sh_up_r;
  logic [IW-1:0]     wr1_a_r, wr2_a_r, sh_ptr_r, sh_end_r;
  ent_t              wr1_e_r, wr2_e_r;
  logic [1:0]        sh_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      top_r      <= '0;
      nf_valid_r <= 1'b0;
      nf_pos_r   <= '0;
    end else if (cmd.plan) begin
      count_r    <= p_count;
      top_r      <= p_top;
      nf_valid_r <= p_nf_valid;
      nf_pos_r   <= p_nf_pos;
    end
    if (cmd.plan) begin
      r_status <= p_status;
      r_off    <= p_off;
      r_reused <= p_reused;
      r_split  <= p_split;
      r_merges <= p_merges;
      wr1_v_r  <= p_wr1_v;
      wr1_a_r  <= p_wr1_a;
      wr1_e_r  <= p_wr1_e;
      wr2_v_r  <= p_wr2_v;
      wr2_a_r  <= p_wr2_a;
      wr2_e_r  <= p_wr2_e;
      sh_up_r  <= p_up;
      sh_d_r   <= p_up ? 2'd1 : mcnt;
      sh_ptr_r <= p_sh_start;
      sh_end_r <= p_sh_end;
    end else if (cmd.shift) begin
      sh_ptr_r <= sh_up_r ? sh_ptr_r - IW'(1) : sh_ptr_r + IW'(1);
    end
  end

  assign stat.sh_last = (sh_ptr_r == sh_end_r);

  // shift engine: read one entry a cycle, write it one place up (split) or one or two places down (merge) the next
  logic          sv_r;
  logic [IW-1:0] sidx_r, sh_wa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= cmd.shift;
    end
    sidx_r <= sh_ptr_r;
  end

  assign sh_wa = sh_up_r ? sidx_r + IW'(1) : sidx_r - IW'(sh_d_r);

  // table memory
  logic          we;
  logic [IW-1:0] wa, ra;
  ent_t          wd;

  always_comb begin
    we = 1'b0;
    wa = sh_wa;
    wd = rd_q;
    if (sv_r) begin
      we = 1'b1;
    end else if (cmd.wr1 && wr1_v_r) begin
      we = 1'b1;
      wa = wr1_a_r;
      wd = wr1_e_r;
    end else if (cmd.wr2 && wr2_v_r) begin
      we = 1'b1;
      wa = wr2_a_r;
      wd = wr2_e_r;
    end
    ra = cmd.shift ? sh_ptr_r : ptr_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status      <= r_status;
      out_data_offset <= r_off[OFF_W-1:0];
      out_reused      <= r_reused;
      out_split_done  <= r_split;
      out_merges      <= r_merges;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CAP)
    else $error("heap top beyond address space");

  a_shift_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> (XW'(sh_wa) < XW'(count_r)))
    else $error("shift write outside occupied table");

  a_plan_edit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.plan && p_go |-> p_wr1_v)
    else $error("table shift planned without entry update");
`endif

endmodule

// ===== sv/heap_block_allocator_unit.sv =====
// Heap block allocator. Each input transfer is an allocate (in_tuser = 0) or a release
// (in_tuser = 1); each gives exactly one result transfer. The block table is a single
// memory with one read and one write port, so each item is a full scan of the N blocks in
// the table (one entry per cycle), a shift of entries for a split or a merge when entries
// move, and the steps to accept, drain, plan, update and hand off the result. Configuration
// (fit policy, heap limit, header size) is written through cfg_we/cfg_index/cfg_data.
// A finished result waits in the output register while the next item is taken; a result
// still held there when the next one is ready stalls the block until it is taken.
module heap_block_allocator_unit #(
  parameter int MAX_BLOCKS = hba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = hba_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // request_size [19:0], block_offset [39:20]
  input  logic [hba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status [1:0], data_offset [21:2], reused [22], split_done [23], merges [25:24]
  output logic [hba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [hba_pkg::CFGI_W-1:0]      cfg_index,
  input  logic [hba_pkg::CFGD_W-1:0]      cfg_data
);
  import hba_pkg::*;

  hba_cmd_t          cmd;
  hba_stat_t         stat;
  logic [STAT_W-1:0] o_status;
  logic [OFF_W-1:0]  o_offset;
  logic              o_reused, o_split;
  logic [MRG_W-1:0]  o_merges;

  hba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  hba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_tuser),
    .in_request_size (in_tdata[REQ_W-1:0]),
    .in_block_offset (in_tdata[REQ_W+OFF_W-1:REQ_W]),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (o_status),
    .out_data_offset (o_offset),
    .out_reused      (o_reused),
    .out_split_done  (o_split),
    .out_merges      (o_merges)
  );

  assign out_tdata = {6'b0, o_merges, o_split, o_reused, o_offset, o_status};

endmodule
